/* src/sha_pkg.sv */
// Shared types for the SHA-256 stream hasher.
`default_nettype none

package sha_pkg;

  typedef logic [31:0] word_t;

  // Index 0 holds H0.
  typedef word_t [7:0] hash_t;

  typedef struct packed {
    logic start;
    logic init;
  } sha_ctrl_t;

endpackage

`default_nettype wire

/* src/sha_compress.sv */
// Iterative SHA-256 compression unit: one round per cycle, chaining words held here.
`default_nettype none

module sha_compress (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sha_pkg::sha_ctrl_t ctrl,
  input  wire logic [511:0]      block,
  output sha_pkg::hash_t         chain,
  output logic                   done
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

  localparam sha_pkg::hash_t IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic sha_pkg::word_t big_sigma0(input sha_pkg::word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic sha_pkg::word_t big_sigma1(input sha_pkg::word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic sha_pkg::word_t small_sigma0(input sha_pkg::word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic sha_pkg::word_t small_sigma1(input sha_pkg::word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  cstate_t        cstate;
  logic [5:0]     rnd;
  sha_pkg::hash_t v;
  sha_pkg::word_t w [16];

  sha_pkg::word_t choose, major, t1, t2, w_next;

  always_comb begin
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + big_sigma1(v[4]) + choose + K[rnd] + w[0];
    t2     = big_sigma0(v[0]) + major;
    w_next = w[0] + small_sigma0(w[1]) + w[9] + small_sigma1(w[14]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
      chain  <= IV;
      done   <= 1'b0;
      rnd    <= 6'd0;
    end else begin
      done <= 1'b0;
      if (ctrl.init) begin
        chain <= IV;
      end
      case (cstate)
        C_IDLE: begin
          if (ctrl.start) begin
            v <= chain;
            for (int i = 0; i < 16; i++) begin
              w[i] <= block[32*(15-i) +: 32];
            end
            rnd    <= 6'd0;
            cstate <= C_ROUND;
          end
        end
        C_ROUND: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_next;
          rnd   <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            cstate <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          done   <= 1'b1;
          cstate <= C_IDLE;
        end
        default: cstate <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer and digest output.
//
// Each input beat carries one message byte (tuser high) or none, and tlast ends the message.
// A byte beat is taken while the top level is idle; every 64th byte then holds the input off
// while the shared round unit runs its 64 rounds, one per cycle, and adds the result into
// the chaining words, so no byte is taken while a block is being compressed.
// A final beat starts padding, which writes one byte a cycle into the block register, pausing
// at the length field and for compressions, up to the end of the block; it takes one or two
// compressions. The digest then leaves as eight 32-bit beats, H0 first, with tlast on the
// eighth, and the block is ready for the next message once the last beat has been taken.
`default_nettype none

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte [7:0]
  input  wire logic        s_axis_tuser,   // byte_present
  input  wire logic        s_axis_tlast,   // is_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // digest_word [31:0]
  output logic             m_axis_tlast    // last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_PAD80, S_PADZERO, S_PADLEN, S_OUT
  } state_t;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;

  state_t             state;
  state_t             ret_state;
  logic [511:0]       blk;
  logic [5:0]         fill;
  logic [63:0]        message_bits;
  logic [2:0]         out_idx;
  sha_pkg::sha_ctrl_t ctrl;
  sha_pkg::hash_t     digest;
  logic               done;

  sha_compress u_compress (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .block (blk),
    .chain (digest),
    .done  (done)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = digest[out_idx];
  assign m_axis_tlast  = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret_state    <= S_IDLE;
      fill         <= 6'd0;
      message_bits <= 64'd0;
      out_idx      <= 3'd0;
      ctrl         <= '0;
    end else begin
      ctrl <= '0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser) begin
              blk          <= {blk[503:0], s_axis_tdata};
              fill         <= fill + 6'd1;
              message_bits <= message_bits + 64'd8;
            end
            if (s_axis_tuser && fill == LAST_BYTE) begin
              ctrl.start <= 1'b1;
              state      <= S_WAIT;
              ret_state  <= s_axis_tlast ? S_PAD80 : S_IDLE;
            end else if (s_axis_tlast) begin
              state <= S_PAD80;
            end
          end
        end
        S_WAIT: begin
          if (done) begin
            state <= ret_state;
          end
        end
        S_PAD80: begin
          blk  <= {blk[503:0], PAD_MARK};
          fill <= fill + 6'd1;
          if (fill == LAST_BYTE) begin
            ctrl.start <= 1'b1;
            state      <= S_WAIT;
            ret_state  <= S_PADZERO;
          end else begin
            state <= S_PADZERO;
          end
        end
        S_PADZERO: begin
          if (fill == LEN_START) begin
            state <= S_PADLEN;
          end else begin
            blk  <= {blk[503:0], 8'h00};
            fill <= fill + 6'd1;
            if (fill == LAST_BYTE) begin
              ctrl.start <= 1'b1;
              state      <= S_WAIT;
              ret_state  <= S_PADZERO;
            end
          end
        end
        S_PADLEN: begin
          blk  <= {blk[503:0], message_bits[{~fill[2:0], 3'b000} +: 8]};
          fill <= fill + 6'd1;
          if (fill == LAST_BYTE) begin
            ctrl.start <= 1'b1;
            state      <= S_WAIT;
            ret_state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              ctrl.init    <= 1'b1;
              fill         <= 6'd0;
              message_bits <= 64'd0;
              state        <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the SHA-256 stream hasher, with a built-in digest predictor.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_BEATS = 65;

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    sha_pkg::word_t word;
    logic           last;
  } digest_beat_t;

  class digest_scoreboard;
    sha_pkg::word_t chain [8];
    logic [7:0]     blk [64];
    int unsigned    fill;
    logic [63:0]    bit_len;
    digest_beat_t   digest_words [$];
    int unsigned    errors;
    int unsigned    words_checked;
    int unsigned    messages;
    int unsigned    bytes_hashed;
    int unsigned    idle_beats;
    int unsigned    spilled_pads;

    function new();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
      fill = 0;
      bit_len = 64'd0;
    endfunction

    function sha_pkg::word_t rotr(sha_pkg::word_t v, int unsigned n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function void compress();
      sha_pkg::word_t w [64];
      sha_pkg::word_t a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 16; t++)
        w[t] = {blk[4 * t], blk[4 * t + 1], blk[4 * t + 2], blk[4 * t + 3]};
      for (int t = 16; t < 64; t++)
        w[t] = w[t - 16] + w[t - 7]
             + (rotr(w[t - 15], 7) ^ rotr(w[t - 15], 18) ^ (w[t - 15] >> 3))
             + (rotr(w[t - 2], 17) ^ rotr(w[t - 2], 19) ^ (w[t - 2] >> 10));
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[t] + w[t];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Works out the digest words that an accepted input beat releases, if any.
    function void note_beat(logic [7:0] data, logic present, logic last);
      digest_beat_t beat;
      if (present) begin
        blk[fill] = data;
        fill++;
        bit_len += 64'd8;
        bytes_hashed++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end else if (!last) begin
        idle_beats++;
      end
      if (!last) return;
      blk[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin
          blk[fill] = 8'h00;
          fill++;
        end
        compress();
        fill = 0;
        spilled_pads++;
      end
      while (fill < 56) begin
        blk[fill] = 8'h00;
        fill++;
      end
      for (int k = 0; k < 8; k++) blk[56 + k] = bit_len[63 - 8 * k -: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
        beat.word = chain[k];
        beat.last = (k == 7);
        digest_words.push_back(beat);
      end
      messages++;
      restart();
    endfunction

    function void check_word(sha_pkg::word_t word, logic last);
      digest_beat_t want;
      words_checked++;
      if (digest_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("error: digest beat %h (last %b) arrived with none outstanding", word, last);
        return;
      end
      want = digest_words.pop_front();
      if (word !== want.word || last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("error: digest beat %0d expected %h last %b, got %h last %b",
                   words_checked, want.word, want.last, word, last);
      end
    endfunction

    function int unsigned pending();
      return digest_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  digest_scoreboard sb;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  logic        hold_requested;
  bit          hold_served;
  int unsigned cycle_count;

  sha256_stream_hasher dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_beat(input logic [7:0] data, input logic present, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= present;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_beat(data, present, last);
  endtask

  task automatic random_messages(input int unsigned beat_budget);
    int unsigned sent;
    int unsigned len;
    bit end_on_byte;
    sent = 0;
    while (sent < beat_budget) begin
      case ($urandom_range(9))
        0, 1, 2, 3: len = $urandom_range(12);
        4, 5, 6:    len = $urandom_range(54, 13);
        7, 8:       len = $urandom_range(64, 55);
        default:    len = $urandom_range(130, 100);
      endcase
      end_on_byte = (len != 0) && ($urandom_range(1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          send_beat(8'($urandom), 1'b0, 1'b0);
          sent++;
        end
        send_beat(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        sent++;
      end
      if (!end_on_byte) begin
        send_beat(8'($urandom), 1'b0, 1'b1);
        sent++;
      end
    end
  endtask

  initial begin : receiver
    hold_served = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requested && !hold_served) begin
        hold_served = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: run stopped after %0d cycles with %0d digest words outstanding",
             cycle_count, sb.pending());
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    tx_idle_pct = 20;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'h00;
    s_axis_tuser <= 1'b0;
    s_axis_tlast <= 1'b0;
    hold_requested <= 1'b0;
    rx_stall_pct <= 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    rx_stall_pct <= 53;

    // The empty message, then "abc" ending on its last byte.
    send_beat(8'h5a, 1'b0, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    // Ignored beats around extreme bytes, closed by a beat with no byte.
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    // Single-byte messages with the byte on the final beat.
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);

    random_messages(PHASE_BEATS);
    tx_idle_pct = 53;
    rx_stall_pct <= 20;
    random_messages(PHASE_BEATS);
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    hold_requested <= 1'b1;
    random_messages(PHASE_BEATS);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d bytes, with %0d ignored beats in between.",
             sb.messages, sb.bytes_hashed, sb.idle_beats);
    $display("%0d padding runs spilled into a second block; %0d digest words checked.",
             sb.spilled_pads, sb.words_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sha_pkg.sv
src/sha_compress.sv
src/sha256_stream_hasher.sv
bench/tb.sv
